>>> hw/rtl/ets_pkg.sv
package ets_pkg;

  // defaults for the top-level parameters
  localparam int MIN_LEN_DEF      = 60;
  localparam int BUCKET_WIDTH_DEF = 91;
  localparam int NUM_BUCKETS_DEF  = 16;

  localparam int NUM_CLASSES = 6;
  localparam int CLASS_AW    = 3;

  localparam logic [47:0] BCAST_MAC = '1;
  localparam logic [15:0] ETYPE_IP  = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  localparam logic [7:0] PROTO_NUM_ND   = 8'd77;
  localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;
  localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
  localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;

  // counter read map
  localparam logic [4:0] IDX_PACKETS    = 5'd0;
  localparam logic [4:0] IDX_BYTES      = 5'd1;
  localparam logic [4:0] IDX_BCAST      = 5'd2;
  localparam logic [4:0] IDX_PROTO_BASE = 5'd3;
  localparam logic [4:0] IDX_HIST_BASE  = 5'd9;

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam logic KIND_LOSS   = 1'b1;

  typedef enum logic [2:0] {
    OUT_COUNTED  = 3'd0,
    OUT_SKIPPED  = 3'd1,
    OUT_RUNT     = 3'd2,
    OUT_FILTERED = 3'd3,
    OUT_READ     = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    PC_ND    = 3'd0,
    PC_UDP   = 3'd1,
    PC_TCP   = 3'd2,
    PC_ICMP  = 3'd3,
    PC_ARP   = 3'd4,
    PC_OTHER = 3'd5
  } pclass_t;

  typedef enum logic [2:0] {
    RS_PACKETS = 3'd0,
    RS_BYTES   = 3'd1,
    RS_BCAST   = 3'd2,
    RS_PROTO   = 3'd3,
    RS_HIST    = 3'd4,
    RS_ZERO    = 3'd5
  } rsel_t;

  typedef enum logic [2:0] {
    CFG_SRC_VAL    = 3'd0,
    CFG_SRC_MASK   = 3'd1,
    CFG_DST_VAL    = 3'd2,
    CFG_DST_MASK   = 3'd3,
    CFG_PROTO_VAL  = 3'd4,
    CFG_PROTO_MASK = 3'd5,
    CFG_LEN_LOW    = 3'd6,
    CFG_LEN_HIGH   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] src_val;
    logic [31:0] src_mask;
    logic [31:0] dst_val;
    logic [31:0] dst_mask;
    logic [7:0]  proto_val;
    logic [7:0]  proto_mask;
    logic [10:0] len_low;
    logic [10:0] len_high;
  } cfg_regs_t;

  typedef struct packed {
    outcome_t outcome;
    logic     bcast;
    pclass_t  pclass;
    logic     counted;
  } cls_info_t;

endpackage

>>> hw/rtl/ets_cfg_regs.sv
module ets_cfg_regs
  import ets_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   cfg
);

  cfg_regs_t cfg_r;
  cfg_idx_t  idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        CFG_SRC_VAL:    cfg_r.src_val    <= pwdata;
        CFG_SRC_MASK:   cfg_r.src_mask   <= pwdata;
        CFG_DST_VAL:    cfg_r.dst_val    <= pwdata;
        CFG_DST_MASK:   cfg_r.dst_mask   <= pwdata;
        CFG_PROTO_VAL:  cfg_r.proto_val  <= pwdata[7:0];
        CFG_PROTO_MASK: cfg_r.proto_mask <= pwdata[7:0];
        CFG_LEN_LOW:    cfg_r.len_low    <= pwdata[10:0];
        CFG_LEN_HIGH:   cfg_r.len_high   <= pwdata[10:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_SRC_VAL:    prdata = cfg_r.src_val;
      CFG_SRC_MASK:   prdata = cfg_r.src_mask;
      CFG_DST_VAL:    prdata = cfg_r.dst_val;
      CFG_DST_MASK:   prdata = cfg_r.dst_mask;
      CFG_PROTO_VAL:  prdata = {24'd0, cfg_r.proto_val};
      CFG_PROTO_MASK: prdata = {24'd0, cfg_r.proto_mask};
      CFG_LEN_LOW:    prdata = {21'd0, cfg_r.len_low};
      CFG_LEN_HIGH:   prdata = {21'd0, cfg_r.len_high};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/ets_classify.sv
module ets_classify
  import ets_pkg::*;
#(
  parameter int MIN_LEN      = MIN_LEN_DEF,
  parameter int BUCKET_WIDTH = BUCKET_WIDTH_DEF,
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BKT_W        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
)
(
  input  cfg_regs_t         cfg,
  input  logic              mode,
  input  logic              capture_kind,
  input  logic [10:0]       wire_len,
  input  logic [47:0]       dest_mac,
  input  logic [15:0]       frame_type,
  input  logic [7:0]        ip_proto,
  input  logic [31:0]       ip_source,
  input  logic [31:0]       ip_dest,
  input  logic [31:0]       arp_sender_ip,
  input  logic [31:0]       arp_target_ip,
  output cls_info_t         info,
  output logic [BKT_W-1:0]  bucket
);

  logic        is_ip;
  logic        is_arp;
  logic        runt;
  logic        src_ok;
  logic        dst_ok;
  logic        proto_ok;
  logic        len_ok;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  pclass_t     pclass;

  assign is_ip  = (frame_type == ETYPE_IP);
  assign is_arp = (frame_type == ETYPE_ARP);
  assign runt   = (32'(wire_len) < 32'(MIN_LEN));

  assign src_addr = is_ip ? ip_source : arp_sender_ip;
  assign dst_addr = is_ip ? ip_dest   : arp_target_ip;

  // a disabled filter passes; address filters fail anything but ip or arp
  assign src_ok = (cfg.src_mask == '0) ||
                  ((is_ip || is_arp) &&
                   ((src_addr & cfg.src_mask) == (cfg.src_val & cfg.src_mask)));
  assign dst_ok = (cfg.dst_mask == '0) ||
                  ((is_ip || is_arp) &&
                   ((dst_addr & cfg.dst_mask) == (cfg.dst_val & cfg.dst_mask)));
  assign proto_ok = (cfg.proto_mask == '0) ||
                    (is_ip && ((ip_proto & cfg.proto_mask) ==
                               (cfg.proto_val & cfg.proto_mask)));
  assign len_ok = (cfg.len_high == '0) ||
                  ((wire_len >= cfg.len_low) && (wire_len <= cfg.len_high));

  always_comb begin
    if (is_arp) begin
      pclass = PC_ARP;
    end else if (is_ip) begin
      case (ip_proto)
        PROTO_NUM_ND:   pclass = PC_ND;
        PROTO_NUM_UDP:  pclass = PC_UDP;
        PROTO_NUM_TCP:  pclass = PC_TCP;
        PROTO_NUM_ICMP: pclass = PC_ICMP;
        default:        pclass = PC_OTHER;
      endcase
    end else begin
      pclass = PC_OTHER;
    end
  end

  // bucket edges are constants, so the division becomes a row of compares;
  // the highest edge reached wins and the last bucket absorbs oversize
  always_comb begin
    bucket = '0;
    for (int k = 1; k < NUM_BUCKETS; k++) begin
      if (32'(wire_len) >= 32'(MIN_LEN + k * BUCKET_WIDTH)) begin
        bucket = BKT_W'(k);
      end
    end
  end

  always_comb begin
    info = '{outcome: OUT_COUNTED, bcast: 1'b0, pclass: PC_ND, counted: 1'b0};
    if (mode == MODE_READ) begin
      info.outcome = OUT_READ;
    end else if (capture_kind == KIND_LOSS) begin
      info.outcome = OUT_SKIPPED;
    end else if (runt) begin
      info.outcome = OUT_RUNT;
    end else if (!(src_ok && dst_ok && proto_ok && len_ok)) begin
      info.outcome = OUT_FILTERED;
    end else begin
      info.outcome = OUT_COUNTED;
      info.counted = 1'b1;
      info.bcast   = (dest_mac == BCAST_MAC);
      info.pclass  = pclass;
    end
  end

endmodule

>>> hw/rtl/ets_count_ram.sv
module ets_count_ram
  import ets_pkg::*;
#(
  parameter int DEPTH = NUM_CLASSES,
  parameter int AW    = CLASS_AW
)
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          upd_en,
  output logic [31:0]   cur_value
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [31:0]      rd_data_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic             last_wr_r;
  logic [AW-1:0]    last_addr_r;
  logic [31:0]      last_data_r;

  // the write of the previous entry lands at the same edge as this read,
  // so a hit on it takes the forwarded value
  always_comb begin
    if (last_wr_r && (last_addr_r == rd_addr_r)) begin
      cur_value = last_data_r;
    end else if (rd_vld_r) begin
      cur_value = rd_data_r;
    end else begin
      cur_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      mem[rd_addr_r] <= cur_value + 32'd1;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= rd_addr;
    end
    if (upd_en) begin
      last_addr_r <= rd_addr_r;
      last_data_r <= cur_value + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      last_wr_r <= 1'b0;
    end else begin
      if (upd_en) begin
        valid_r[rd_addr_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
      // held while the reading item waits, so a stalled item keeps its forward
      if (rd_en || upd_en) begin
        last_wr_r <= upd_en;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_on_reset: assert property (@(posedge clk) !rst_n |=> (valid_r == '0))
    else $error("count ram valid bits not cleared by reset");

  a_fwd_value: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> (last_wr_r && (last_data_r == $past(cur_value) + 32'd1)))
    else $error("forwarded count does not follow update");

  a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> valid_r[last_addr_r])
    else $error("updated entry not marked valid");

  a_no_zero_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && rd_en && (rd_addr == rd_addr_r)) |=> (cur_value == last_data_r))
    else $error("read after write to same entry missed forwarding");
`endif

endmodule

>>> hw/rtl/ethernet_traffic_statistics.sv
// ethernet traffic statistics
//
// input channel (in_valid/in_ready): one item per transfer, either a captured
// packet header (in_mode 0) or a counter read (in_mode 1, in_counter_index).
// output channel (out_valid/out_ready): exactly one result per input item, in
// order: outcome, broadcast flag, protocol class, size bucket, read value.
// configuration: apb-style port (psel/penable/pwrite/paddr/pwdata), register
// i at byte address 4*i, pready tied high; write only while the block is idle.
// path: a result is registered in the update stage, then the output register.
// throughput: one item per cycle unless the output stalls; the per-class and
// histogram counts sit in two small synchronous rams read at acceptance and
// written as the item leaves the update stage, with the last write forwarded
// when back-to-back items hit the same entry.
// reset (rst_n low, synchronous): registers and all counters read as zero;
// ram entries carry valid bits cleared at once, so no clearing pass is needed
// and the first item may be taken in the cycle after reset.
// stall: with out_ready low the result stays in the output register, one
// more item waits in the update stage, and then in_ready drops.
module ethernet_traffic_statistics
  import ets_pkg::*;
#(
  parameter int MIN_LEN      = MIN_LEN_DEF,
  parameter int BUCKET_WIDTH = BUCKET_WIDTH_DEF,
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic        in_capture_kind,
  input  logic [10:0] in_wire_len,
  input  logic [47:0] in_dest_mac,
  input  logic [15:0] in_frame_type,
  input  logic [7:0]  in_ip_proto,
  input  logic [31:0] in_ip_source,
  input  logic [31:0] in_ip_dest,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [31:0] in_arp_target_ip,
  input  logic [4:0]  in_counter_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic        out_is_broadcast,
  output logic [2:0]  out_proto_class,
  output logic [3:0]  out_size_bucket,
  output logic [31:0] out_read_value
);

  localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  cfg_regs_t        cfg;
  cls_info_t        info;
  logic [BKT_W-1:0] bucket;

  // update stage
  logic             s1_valid_r;
  cls_info_t        s1_info_r;
  logic [BKT_W-1:0] s1_bucket_r;
  logic [10:0]      s1_len_r;
  rsel_t            s1_rsel_r;

  // output register
  logic             out_valid_r;
  outcome_t         out_outcome_r;
  logic             out_bcast_r;
  pclass_t          out_pclass_r;
  logic [3:0]       out_bucket_r;
  logic [31:0]      out_rval_r;

  // scalar counters
  logic [31:0] packet_count_r;
  logic [31:0] byte_count_r;
  logic [31:0] bcast_count_r;

  logic             in_xfer;
  logic             s1_go;
  logic             s1_count;
  rsel_t            rsel;
  logic [4:0]       proto_off;
  logic [4:0]       hist_off;
  logic             proto_hit;
  logic             hist_hit;
  logic [CLASS_AW-1:0] proto_addr;
  logic [BKT_W-1:0] hist_addr;
  logic [31:0]      proto_cur;
  logic [31:0]      hist_cur;
  logic [31:0]      rval;
  logic [31:0]      bucket_ext;

  ets_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ets_classify #(
    .MIN_LEN      (MIN_LEN),
    .BUCKET_WIDTH (BUCKET_WIDTH),
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BKT_W        (BKT_W)
  ) u_classify (
    .cfg           (cfg),
    .mode          (in_mode),
    .capture_kind  (in_capture_kind),
    .wire_len      (in_wire_len),
    .dest_mac      (in_dest_mac),
    .frame_type    (in_frame_type),
    .ip_proto      (in_ip_proto),
    .ip_source     (in_ip_source),
    .ip_dest       (in_ip_dest),
    .arp_sender_ip (in_arp_sender_ip),
    .arp_target_ip (in_arp_target_ip),
    .info          (info),
    .bucket        (bucket)
  );

  // handshake: the update stage drains whenever the output register frees up
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;
  assign s1_count = s1_go && s1_info_r.counted;

  // counter read decode
  assign proto_off = in_counter_index - IDX_PROTO_BASE;
  assign hist_off  = in_counter_index - IDX_HIST_BASE;
  assign proto_hit = (in_counter_index >= IDX_PROTO_BASE) &&
                     (32'(proto_off) < 32'(NUM_CLASSES));
  assign hist_hit  = (in_counter_index >= IDX_HIST_BASE) &&
                     (32'(hist_off) < 32'(NUM_BUCKETS));

  always_comb begin
    if (in_mode != MODE_READ) begin
      rsel = RS_ZERO;
    end else if (in_counter_index == IDX_PACKETS) begin
      rsel = RS_PACKETS;
    end else if (in_counter_index == IDX_BYTES) begin
      rsel = RS_BYTES;
    end else if (in_counter_index == IDX_BCAST) begin
      rsel = RS_BCAST;
    end else if (proto_hit) begin
      rsel = RS_PROTO;
    end else if (hist_hit) begin
      rsel = RS_HIST;
    end else begin
      rsel = RS_ZERO;
    end
  end

  // ram addresses: the packet's class and bucket, or the counter being read;
  // out-of-range reads park on entry zero and are never used
  always_comb begin
    if (in_mode == MODE_READ) begin
      proto_addr = proto_hit ? proto_off[CLASS_AW-1:0] : '0;
      hist_addr  = hist_hit  ? BKT_W'(hist_off)        : '0;
    end else begin
      proto_addr = CLASS_AW'(info.pclass);
      hist_addr  = bucket;
    end
  end

  ets_count_ram #(
    .DEPTH (NUM_CLASSES),
    .AW    (CLASS_AW)
  ) u_proto_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_xfer),
    .rd_addr   (proto_addr),
    .upd_en    (s1_count),
    .cur_value (proto_cur)
  );

  ets_count_ram #(
    .DEPTH (NUM_BUCKETS),
    .AW    (BKT_W)
  ) u_hist_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_xfer),
    .rd_addr   (hist_addr),
    .upd_en    (s1_count),
    .cur_value (hist_cur)
  );

  // update stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_info_r   <= info;
      s1_bucket_r <= bucket;
      s1_len_r    <= in_wire_len;
      s1_rsel_r   <= rsel;
    end
  end

  // scalar counters, all wrapping at 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_count_r <= '0;
      byte_count_r   <= '0;
      bcast_count_r  <= '0;
    end else if (s1_count) begin
      packet_count_r <= packet_count_r + 32'd1;
      byte_count_r   <= byte_count_r + 32'(s1_len_r);
      if (s1_info_r.bcast) begin
        bcast_count_r <= bcast_count_r + 32'd1;
      end
    end
  end

  // read value, taken after every earlier item has updated
  always_comb begin
    case (s1_rsel_r)
      RS_PACKETS: rval = packet_count_r;
      RS_BYTES:   rval = byte_count_r;
      RS_BCAST:   rval = bcast_count_r;
      RS_PROTO:   rval = proto_cur;
      RS_HIST:    rval = hist_cur;
      default:    rval = '0;
    endcase
  end

  assign bucket_ext = s1_info_r.counted ? 32'(s1_bucket_r) : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_outcome_r <= s1_info_r.outcome;
      out_bcast_r   <= s1_info_r.bcast;
      out_pclass_r  <= s1_info_r.pclass;
      out_bucket_r  <= bucket_ext[3:0];
      out_rval_r    <= rval;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_is_broadcast = out_bcast_r;
  assign out_proto_class  = out_pclass_r;
  assign out_size_bucket  = out_bucket_r;
  assign out_read_value   = out_rval_r;

endmodule
